// ===== hw/rtl/scaled_pixel_formatter_assert.svh =====
// Assertion macros for the scaled pixel formatter; spf_back is the module that includes them.
`ifndef SCALED_PIXEL_FORMATTER_ASSERT_SVH
`define SCALED_PIXEL_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

`define SPF_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spf: implication check failed");

`define SPF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spf: next-cycle check failed");

`else

`define SPF_ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define SPF_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/spf_pkg.sv =====
package spf_pkg;

	localparam int POS_W = 12;
	localparam int DIM_W = 13;
	localparam int STRIDE_W = 16;
	localparam int SHIFT_W = 5;
	localparam int COLOUR_W = 24;
	localparam int INDEX_W = 20;
	localparam int OFFSET_W = 29;
	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_MAP = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [1:0] DEPTH_32 = 2'd0;
	localparam logic [1:0] DEPTH_565 = 2'd1;

	localparam logic WSIZE_FOUR = 1'b0;
	localparam logic WSIZE_TWO = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_SHIFT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SHIFT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SHIFT = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0] dest_width;
		logic [DIM_W-1:0] dest_height;
		logic [STRIDE_W-1:0] line_stride;
		logic [1:0] depth_mode;
		logic [SHIFT_W-1:0] red_shift;
		logic [SHIFT_W-1:0] green_shift;
		logic [SHIFT_W-1:0] blue_shift;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dest_width: 13'd640,
		dest_height: 13'd480,
		line_stride: 16'd2560,
		depth_mode: DEPTH_32,
		red_shift: 5'd16,
		green_shift: 5'd8,
		blue_shift: 5'd0
	};

	typedef struct packed {
		logic write_enable;
		logic [OFFSET_W-1:0] byte_offset;
		logic [WORD_W-1:0] write_word;
		logic write_size;
	} put_res_t;

endpackage

// ===== hw/rtl/spf_front.sv =====
module spf_front #(
	parameter int SRC_WIDTH = 1024,
	parameter int SRC_HEIGHT = 1024,
	parameter int DW = 23
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic cmd,
	input logic [spf_pkg::POS_W-1:0] pos_x,
	input logic [spf_pkg::POS_W-1:0] pos_y,
	input logic [spf_pkg::COLOUR_W-1:0] colour,
	input spf_pkg::cfg_t cfg,
	output logic valid_s1,
	output logic cmd_s1,
	output logic [DW-1:0] dvd_x_s1,
	output logic [DW-1:0] dvd_y_s1,
	output spf_pkg::put_res_t put_s1
);
	import spf_pkg::*;

	localparam logic [DW-1:0] SRC_W_D = DW'(SRC_WIDTH);
	localparam logic [DW-1:0] SRC_H_D = DW'(SRC_HEIGHT);

	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic in_frame;
	logic [OFFSET_W-1:0] line_off;
	put_res_t put_c;

	assign red = colour[23:16];
	assign green = colour[15:8];
	assign blue = colour[7:0];
	assign in_frame = ({1'b0, pos_x} < cfg.dest_width) && ({1'b0, pos_y} < cfg.dest_height);
	assign line_off = OFFSET_W'(pos_y) * OFFSET_W'(cfg.line_stride);

	always_comb begin
		put_c = '0;
		if (in_frame) begin
			case (cfg.depth_mode)
				DEPTH_32: begin
					put_c.write_enable = 1'b1;
					put_c.write_size = WSIZE_FOUR;
					put_c.byte_offset = line_off + OFFSET_W'({pos_x, 2'b00});
					put_c.write_word = (WORD_W'(red) << cfg.red_shift)
						| (WORD_W'(green) << cfg.green_shift)
						| (WORD_W'(blue) << cfg.blue_shift);
				end
				DEPTH_565: begin
					put_c.write_enable = 1'b1;
					put_c.write_size = WSIZE_TWO;
					put_c.byte_offset = line_off + OFFSET_W'({pos_x, 1'b0});
					put_c.write_word = {16'd0, red[7:3], green[7:2], blue[7:3]};
				end
				default: begin
					put_c = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		dvd_x_s1 <= DW'(pos_x) * SRC_W_D;
		dvd_y_s1 <= DW'(pos_y) * SRC_H_D;
		put_s1 <= put_c;
	end

endmodule

// ===== hw/rtl/spf_div_cell.sv =====
module spf_div_cell #(
	parameter int DW = 23
) (
	input logic clk,
	input logic arst_n,
	input logic [spf_pkg::DIM_W-1:0] div_x,
	input logic [spf_pkg::DIM_W-1:0] div_y,
	input logic prev_valid,
	input logic prev_cmd,
	input logic [spf_pkg::DIM_W-1:0] prev_rem_x,
	input logic [DW-1:0] prev_dq_x,
	input logic [spf_pkg::DIM_W-1:0] prev_rem_y,
	input logic [DW-1:0] prev_dq_y,
	input spf_pkg::put_res_t prev_put,
	output logic next_valid,
	output logic next_cmd,
	output logic [spf_pkg::DIM_W-1:0] next_rem_x,
	output logic [DW-1:0] next_dq_x,
	output logic [spf_pkg::DIM_W-1:0] next_rem_y,
	output logic [DW-1:0] next_dq_y,
	output spf_pkg::put_res_t next_put
);
	import spf_pkg::*;

	logic valid_q;
	logic cmd_q;
	logic [DIM_W-1:0] rem_x_q;
	logic [DW-1:0] dq_x_q;
	logic [DIM_W-1:0] rem_y_q;
	logic [DW-1:0] dq_y_q;
	put_res_t put_q;

	logic [DIM_W:0] trial_x;
	logic [DIM_W:0] trial_y;
	logic ge_x;
	logic ge_y;
	logic [DIM_W-1:0] rem_x_c;
	logic [DIM_W-1:0] rem_y_c;

	// one restoring-division step per lane: bring down a dividend bit, try subtract
	assign trial_x = {prev_rem_x, prev_dq_x[DW-1]};
	assign trial_y = {prev_rem_y, prev_dq_y[DW-1]};
	assign ge_x = trial_x >= {1'b0, div_x};
	assign ge_y = trial_y >= {1'b0, div_y};
	assign rem_x_c = ge_x ? DIM_W'(trial_x - {1'b0, div_x}) : trial_x[DIM_W-1:0];
	assign rem_y_c = ge_y ? DIM_W'(trial_y - {1'b0, div_y}) : trial_y[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= prev_cmd;
		rem_x_q <= rem_x_c;
		rem_y_q <= rem_y_c;
		dq_x_q <= {prev_dq_x[DW-2:0], ge_x};
		dq_y_q <= {prev_dq_y[DW-2:0], ge_y};
		put_q <= prev_put;
	end

	assign next_valid = valid_q;
	assign next_cmd = cmd_q;
	assign next_rem_x = rem_x_q;
	assign next_dq_x = dq_x_q;
	assign next_rem_y = rem_y_q;
	assign next_dq_y = dq_y_q;
	assign next_put = put_q;

endmodule

// ===== hw/rtl/spf_back.sv =====
`include "scaled_pixel_formatter_assert.svh"

module spf_back #(
	parameter int SRC_WIDTH = 1024,
	parameter int SRC_HEIGHT = 1024,
	parameter int DW = 23
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic cmd,
	input logic [DW-1:0] quo_x,
	input logic [DW-1:0] quo_y,
	input spf_pkg::put_res_t put,
	input spf_pkg::cfg_t cfg,
	output logic done,
	output logic [spf_pkg::INDEX_W-1:0] source_index,
	output logic write_enable,
	output logic [spf_pkg::OFFSET_W-1:0] byte_offset,
	output logic [spf_pkg::WORD_W-1:0] write_word,
	output logic write_size
);
	import spf_pkg::*;

	localparam int PW = DW + DIM_W;
	localparam logic [DW-1:0] SRC_W_D = DW'(SRC_WIDTH);
	localparam logic [DW-1:0] SRC_H_D = DW'(SRC_HEIGHT);
	localparam logic [PW-1:0] SRC_W_P = PW'(SRC_WIDTH);

	logic [DW-1:0] sx;
	logic [DW-1:0] sy;
	logic [PW-1:0] lin;
	logic [INDEX_W-1:0] index_c;

	logic done_q;
	logic [INDEX_W-1:0] index_q;
	put_res_t put_q;

	always_comb begin
		if (cfg.dest_width == '0) begin
			sx = '0;
		end else if (quo_x >= SRC_W_D) begin
			sx = SRC_W_D - DW'(1);
		end else begin
			sx = quo_x;
		end
		if (cfg.dest_height == '0) begin
			sy = '0;
		end else if (quo_y >= SRC_H_D) begin
			sy = SRC_H_D - DW'(1);
		end else begin
			sy = quo_y;
		end
	end

	assign lin = PW'(sy) * SRC_W_P + PW'(sx);
	assign index_c = lin[INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_MAP) begin
			index_q <= index_c;
			put_q <= '0;
		end else begin
			index_q <= '0;
			put_q <= put;
		end
	end

	assign done = done_q;
	assign source_index = index_q;
	assign write_enable = put_q.write_enable;
	assign byte_offset = put_q.byte_offset;
	assign write_word = put_q.write_word;
	assign write_size = put_q.write_size;

	`SPF_ASSERT_IMPLY(a_two_byte_writes, clk, arst_n, done_q && put_q.write_size, put_q.write_enable)
	`SPF_ASSERT_IMPLY(a_565_upper_zero, clk, arst_n, done_q && put_q.write_size, put_q.write_word[31:16] == 16'd0)
	`SPF_ASSERT_IMPLY(a_write_no_index, clk, arst_n, done_q && put_q.write_enable, index_q == '0)
	`SPF_ASSERT_NEXT(a_done_follows_valid, clk, arst_n, !valid, !done_q)

endmodule

// ===== hw/rtl/scaled_pixel_formatter.sv =====
// Pipeline: the start edge loads the front stage; DW division cells and one output stage follow,
//   with DW = 12 + clog2(max source side + 1); done rises when an item leaves the output stage.
// Throughput: one item per cycle; busy is always low and the row of division cells sets the depth.
// Reset: arst_n resets cfg_q and clears only the valid bits, emptying the pipeline at once.
// done pulses for one cycle per item; the receiver cannot stall.
module scaled_pixel_formatter #(
	parameter int SRC_WIDTH = 1024,
	parameter int SRC_HEIGHT = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_write,
	input logic [spf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [spf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic cmd,
	input logic [spf_pkg::POS_W-1:0] pos_x,
	input logic [spf_pkg::POS_W-1:0] pos_y,
	input logic [spf_pkg::COLOUR_W-1:0] colour,
	output logic done,
	output logic [spf_pkg::INDEX_W-1:0] source_index,
	output logic write_enable,
	output logic [spf_pkg::OFFSET_W-1:0] byte_offset,
	output logic [spf_pkg::WORD_W-1:0] write_word,
	output logic write_size
);
	import spf_pkg::*;

	localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int DW = POS_W + $clog2(SRC_MAX + 1);

	cfg_t cfg_q;

	logic chain_valid [0:DW];
	logic chain_cmd [0:DW];
	logic [DIM_W-1:0] chain_rem_x [0:DW];
	logic [DW-1:0] chain_dq_x [0:DW];
	logic [DIM_W-1:0] chain_rem_y [0:DW];
	logic [DW-1:0] chain_dq_y [0:DW];
	put_res_t chain_put [0:DW];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DEST_WIDTH: cfg_q.dest_width <= cfg_data[DIM_W-1:0];
				CFG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data[DIM_W-1:0];
				CFG_LINE_STRIDE: cfg_q.line_stride <= cfg_data[STRIDE_W-1:0];
				CFG_DEPTH_MODE: cfg_q.depth_mode <= cfg_data[1:0];
				CFG_RED_SHIFT: cfg_q.red_shift <= cfg_data[SHIFT_W-1:0];
				CFG_GREEN_SHIFT: cfg_q.green_shift <= cfg_data[SHIFT_W-1:0];
				CFG_BLUE_SHIFT: cfg_q.blue_shift <= cfg_data[SHIFT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	spf_front #(
		.SRC_WIDTH(SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.DW(DW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.valid(start && !busy),
		.cmd(cmd),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.colour(colour),
		.cfg(cfg_q),
		.valid_s1(chain_valid[0]),
		.cmd_s1(chain_cmd[0]),
		.dvd_x_s1(chain_dq_x[0]),
		.dvd_y_s1(chain_dq_y[0]),
		.put_s1(chain_put[0])
	);

	assign chain_rem_x[0] = '0;
	assign chain_rem_y[0] = '0;

	for (genvar k = 0; k < DW; k++) begin : g_cell
		spf_div_cell #(
			.DW(DW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.div_x(cfg_q.dest_width),
			.div_y(cfg_q.dest_height),
			.prev_valid(chain_valid[k]),
			.prev_cmd(chain_cmd[k]),
			.prev_rem_x(chain_rem_x[k]),
			.prev_dq_x(chain_dq_x[k]),
			.prev_rem_y(chain_rem_y[k]),
			.prev_dq_y(chain_dq_y[k]),
			.prev_put(chain_put[k]),
			.next_valid(chain_valid[k+1]),
			.next_cmd(chain_cmd[k+1]),
			.next_rem_x(chain_rem_x[k+1]),
			.next_dq_x(chain_dq_x[k+1]),
			.next_rem_y(chain_rem_y[k+1]),
			.next_dq_y(chain_dq_y[k+1]),
			.next_put(chain_put[k+1])
		);
	end

	spf_back #(
		.SRC_WIDTH(SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.DW(DW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.valid(chain_valid[DW]),
		.cmd(chain_cmd[DW]),
		.quo_x(chain_dq_x[DW]),
		.quo_y(chain_dq_y[DW]),
		.put(chain_put[DW]),
		.cfg(cfg_q),
		.done(done),
		.source_index(source_index),
		.write_enable(write_enable),
		.byte_offset(byte_offset),
		.write_word(write_word),
		.write_size(write_size)
	);

endmodule
